@@ hdl/mbid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbid_pkg
// shared types and constants for the multi-bit integrating debouncer
// ----------------------------------------------------------------------------
package mbid_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 4;
    localparam int OPC_W    = 2;
    localparam int BIDX_W   = 5;
    localparam int CFG_IDX_W = 1;

    // opcodes of an input transaction
    localparam logic [OPC_W-1:0] OPC_INIT     = 2'd0;
    localparam logic [OPC_W-1:0] OPC_SAMPLE   = 2'd1;
    localparam logic [OPC_W-1:0] OPC_SNAPSHOT = 2'd2;

    // result kinds
    localparam logic KIND_CHANGE   = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd1;

    // configuration reset values
    localparam logic [DATA_W-1:0] RESET_INVERT_MASK = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]  RESET_THRESHOLD   = 4'd3;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] sample_word;
    } t_item;

    typedef struct packed {
        logic              event_kind;
        logic [BIDX_W-1:0] bit_index;
        logic              level;
        logic [DATA_W-1:0] stable_word;
        logic              last;
    } t_result;

    // queued command: opcode plus the already inverted word
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] word;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

endpackage

@@ hdl/mbid_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbid_front
// accepts input transactions, applies the invert mask and drops items
// that have no effect before queuing them for the back end
// ----------------------------------------------------------------------------
module mbid_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  mbid_pkg::t_item               i_item,
    input  logic [mbid_pkg::DATA_W-1:0]   i_invert_mask,
    input  logic                          i_q_full,
    output logic                          o_push,
    output mbid_pkg::t_cmd                o_cmd
);

    logic r_init;
    logic accept;
    logic is_init;
    logic is_work;

    // classify the incoming transaction
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign is_init = (i_item.opcode == mbid_pkg::OPC_INIT);
    assign is_work = r_init && ((i_item.opcode == mbid_pkg::OPC_SAMPLE) ||
                                (i_item.opcode == mbid_pkg::OPC_SNAPSHOT));

    assign o_push        = accept && (is_init || is_work);
    assign o_cmd.opcode  = i_item.opcode;
    assign o_cmd.word    = i_item.sample_word ^ i_invert_mask;

    // initialized flag, set by the first initialize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
        end else if (accept && is_init) begin
            r_init <= 1'b1;
        end
    end

endmodule

@@ hdl/mbid_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbid_queue
// two-entry command queue decoupling the front end from the back end
// ----------------------------------------------------------------------------
module mbid_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbid_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output mbid_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    mbid_pkg::t_cmd               r_mem [mbid_pkg::Q_DEPTH];
    logic [mbid_pkg::Q_PTR_W-1:0] r_wr;
    logic [mbid_pkg::Q_PTR_W-1:0] r_rd;
    logic [mbid_pkg::Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == mbid_pkg::Q_CNT_W'(mbid_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue underflow");

endmodule

@@ hdl/mbid_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbid_back
// executes queued commands: counter update per input, then, unless stalled, a
// scan over the inputs, at most one result per cycle into the output register
// ----------------------------------------------------------------------------
module mbid_back #(
    parameter int NUM_INPUTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  mbid_pkg::t_cmd                i_q_cmd,
    output logic                          o_pop,
    input  logic [mbid_pkg::CNT_W-1:0]    i_threshold,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mbid_pkg::t_result             o_out_data
);

    localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

    mbid_pkg::t_back_state        r_state, n_state;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [NUM_INPUTS-1:0]        r_pend, n_pend;
    logic                         r_kind, n_kind;
    logic [NUM_INPUTS-1:0]        r_stable, n_stable;
    logic [mbid_pkg::CNT_W-1:0]   r_cnt [NUM_INPUTS];
    logic [mbid_pkg::CNT_W-1:0]   n_cnt [NUM_INPUTS];
    logic                         r_out_valid, n_out_valid;
    mbid_pkg::t_result            r_out, n_out;

    logic [NUM_INPUTS+mbid_pkg::DATA_W-1:0] word_ext;
    logic [NUM_INPUTS-1:0]                  word_n;
    logic [NUM_INPUTS+mbid_pkg::DATA_W-1:0] stable_ext;
    logic [IDX_W+mbid_pkg::BIDX_W-1:0]      idx_ext;
    logic [NUM_INPUTS-1:0]                  lane_stable;
    logic [NUM_INPUTS-1:0]                  lane_flip;
    logic [mbid_pkg::CNT_W-1:0]             lane_cnt [NUM_INPUTS];
    logic [NUM_INPUTS-1:0]                  rest;
    logic                                   slot_free;
    logic                                   is_last;

    // width adaption of the word, stable bits and index
    assign word_ext   = {{NUM_INPUTS{1'b0}}, i_q_cmd.word};
    assign word_n     = word_ext[NUM_INPUTS-1:0];
    assign stable_ext = {{mbid_pkg::DATA_W{1'b0}}, r_stable};
    assign idx_ext    = {{mbid_pkg::BIDX_W{1'b0}}, r_idx};

    // per-input integrating counters, all lanes in parallel
    always_comb begin
        logic [mbid_pkg::CNT_W-1:0] v_c;
        v_c         = '0;
        lane_stable = r_stable;
        lane_flip   = '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            v_c = r_cnt[i];
            if (word_n[i] == r_stable[i]) begin
                if (v_c != '0) begin
                    v_c = v_c - 1'b1;
                end
            end else begin
                if (v_c < i_threshold) begin
                    v_c = v_c + 1'b1;
                end
                if (v_c >= i_threshold) begin
                    v_c            = '0;
                    lane_stable[i] = word_n[i];
                    lane_flip[i]   = 1'b1;
                end
            end
            lane_cnt[i] = v_c;
        end
    end

    // remaining pending inputs after the current one
    always_comb begin
        rest        = r_pend;
        rest[r_idx] = 1'b0;
    end

    assign is_last   = (rest == '0);
    assign slot_free = !r_out_valid || !i_out_stall;

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_kind      = r_kind;
        n_stable    = r_stable;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            mbid_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    case (i_q_cmd.opcode)
                        mbid_pkg::OPC_INIT: begin
                            n_stable = word_n;
                            for (int i = 0; i < NUM_INPUTS; i++) begin
                                n_cnt[i] = '0;
                            end
                        end
                        mbid_pkg::OPC_SAMPLE: begin
                            n_stable = lane_stable;
                            n_cnt    = lane_cnt;
                            n_pend   = lane_flip;
                            n_kind   = mbid_pkg::KIND_CHANGE;
                            n_idx    = '0;
                            if (lane_flip != '0) begin
                                n_state = mbid_pkg::BK_SCAN;
                            end
                        end
                        mbid_pkg::OPC_SNAPSHOT: begin
                            n_pend  = '1;
                            n_kind  = mbid_pkg::KIND_SNAPSHOT;
                            n_idx   = '0;
                            n_state = mbid_pkg::BK_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mbid_pkg::BK_SCAN: begin
                if (r_pend[r_idx]) begin
                    if (slot_free) begin
                        n_out_valid       = 1'b1;
                        n_out.event_kind  = r_kind;
                        n_out.bit_index   = idx_ext[mbid_pkg::BIDX_W-1:0];
                        n_out.level       = r_stable[r_idx];
                        n_out.stable_word = stable_ext[mbid_pkg::DATA_W-1:0];
                        n_out.last        = is_last;
                        n_pend[r_idx]     = 1'b0;
                        n_idx             = r_idx + 1'b1;
                        if (is_last) begin
                            n_state = mbid_pkg::BK_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = mbid_pkg::BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbid_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_stable    <= '0;
            r_pend      <= '0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_stable    <= n_stable;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbid_pkg::BK_SCAN) |-> (r_pend != '0))
        else $error("scan running with nothing pending");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == mbid_pkg::BK_IDLE))
        else $error("command popped during a scan");

endmodule

@@ hdl/multi_bit_integrating_debouncer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_bit_integrating_debouncer_core
// debounces up to NUM_INPUTS input levels with integrating counters and
// reports stable-level changes and snapshots as a stream of results
//
//   channel  | direction | handshake                 | transaction
//   ---------+-----------+---------------------------+--------------------
//   in       | input     | i_in_valid / o_in_stall   | t_item (opcode, word)
//   out      | output    | o_out_valid / i_out_stall | t_result
//   cfg      | input     | i_cfg_valid / o_cfg_ready | register index, data
//
// initialize needs no scan; a sample is followed by a scan up to its highest
// changed input, if any flipped; a snapshot scans all inputs. The scan emits at
// most one result per cycle.
// the front accepts into a two-entry queue while the back end scans.
// synchronous active-low reset clears counters and stable bits and resets cfg.
// a stalled output holds its result and pauses the scan.
// ----------------------------------------------------------------------------
module multi_bit_integrating_debouncer_core #(
    parameter int NUM_INPUTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbid_pkg::t_item                   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbid_pkg::t_result                 o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbid_pkg::DATA_W-1:0]       i_cfg_data
);

    logic [mbid_pkg::DATA_W-1:0] r_invert_mask;
    logic [mbid_pkg::CNT_W-1:0]  r_threshold;
    logic                        q_full;
    logic                        q_push;
    logic                        q_valid;
    logic                        q_pop;
    mbid_pkg::t_cmd              push_cmd;
    mbid_pkg::t_cmd              head_cmd;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_mask <= mbid_pkg::RESET_INVERT_MASK;
            r_threshold   <= mbid_pkg::RESET_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbid_pkg::CFG_INVERT_MASK: r_invert_mask <= i_cfg_data;
                mbid_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[mbid_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    mbid_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_item        (i_in_data),
        .i_invert_mask (r_invert_mask),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    // command queue
    mbid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    // back end
    mbid_back #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_pop       (q_pop),
        .i_threshold (r_threshold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/tb_multi_bit_integrating_debouncer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_bit_integrating_debouncer_core
// self-checking bench for the integrating debouncer core: a directed set of
// corner transactions, then random bouncing pin sequences under several
// invert-mask and threshold settings, with bursty idling on both channels;
// every result is checked against a cycle-free prediction of the debouncer
// ----------------------------------------------------------------------------
module tb_multi_bit_integrating_debouncer_core;

    // opcode the block must ignore
    localparam logic [mbid_pkg::OPC_W-1:0] OPC_UNUSED = 2'd3;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 72;
    // covers the queue of two plus the scan in progress
    localparam int SETTLE_CYCLES   = 110;
    // far above the longest quiet stretch: settle pause, snapshot scan, stalls
    localparam int WATCHDOG_LIMIT  = 4000;

    // prediction of the debouncer and store of the results it must produce
    class debounce_scoreboard;
        logic [mbid_pkg::DATA_W-1:0] invert_mask;
        logic [mbid_pkg::CNT_W-1:0]  threshold;
        bit                          armed;
        logic [mbid_pkg::DATA_W-1:0] stable_levels;
        logic [mbid_pkg::CNT_W-1:0]  integrators [mbid_pkg::DATA_W];
        mbid_pkg::t_result           expected_events [$];
        int                          mismatches;
        int                          items_seen;
        int                          results_checked;
        int                          changes_predicted;
        int                          snapshots_predicted;
        int                          settings_seen;

        function new();
            invert_mask   = mbid_pkg::RESET_INVERT_MASK;
            threshold     = mbid_pkg::RESET_THRESHOLD;
            armed         = 1'b0;
            stable_levels = '0;
            foreach (integrators[i]) integrators[i] = '0;
            mismatches          = 0;
            items_seen          = 0;
            results_checked     = 0;
            changes_predicted   = 0;
            snapshots_predicted = 0;
            settings_seen       = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void write_register(logic [mbid_pkg::CFG_IDX_W-1:0] index,
                                     logic [mbid_pkg::DATA_W-1:0] value);
            settings_seen++;
            case (index)
                mbid_pkg::CFG_INVERT_MASK: invert_mask = value;
                mbid_pkg::CFG_THRESHOLD:   threshold   = value[mbid_pkg::CNT_W-1:0];
                default:                   ;
            endcase
        endfunction

        // update the debouncer state for one accepted transaction
        function void predict_events(mbid_pkg::t_item item);
            logic [mbid_pkg::DATA_W-1:0] word;
            mbid_pkg::t_result           fresh [$];
            mbid_pkg::t_result           res;
            word = item.sample_word ^ invert_mask;
            items_seen++;
            if (item.opcode == mbid_pkg::OPC_INIT) begin
                stable_levels = word;
                foreach (integrators[i]) integrators[i] = '0;
                armed = 1'b1;
                return;
            end
            if (!armed || item.opcode == OPC_UNUSED) return;
            if (item.opcode == mbid_pkg::OPC_SAMPLE) begin
                for (int i = 0; i < mbid_pkg::DATA_W; i++) begin
                    if (word[i] == stable_levels[i]) begin
                        // agreeing sample drains the counter
                        if (integrators[i] != '0) integrators[i] = integrators[i] - 1'b1;
                    end else begin
                        // disagreeing sample integrates; reaching the threshold flips the level and clears the counter
                        if (integrators[i] < threshold) integrators[i] = integrators[i] + 1'b1;
                        if (integrators[i] >= threshold) begin
                            integrators[i]   = '0;
                            stable_levels[i] = word[i];
                            res              = '0;
                            res.event_kind   = mbid_pkg::KIND_CHANGE;
                            res.bit_index    = mbid_pkg::BIDX_W'(i);
                            res.level        = word[i];
                            fresh.push_back(res);
                            changes_predicted++;
                        end
                    end
                end
            end else begin
                // snapshot reports every stable level
                snapshots_predicted++;
                for (int i = 0; i < mbid_pkg::DATA_W; i++) begin
                    res            = '0;
                    res.event_kind = mbid_pkg::KIND_SNAPSHOT;
                    res.bit_index  = mbid_pkg::BIDX_W'(i);
                    res.level      = stable_levels[i];
                    fresh.push_back(res);
                end
            end
            foreach (fresh[k]) begin
                fresh[k].stable_word = stable_levels;
                fresh[k].last        = (k == fresh.size() - 1);
                expected_events.push_back(fresh[k]);
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // compare one accepted result with the oldest expectation
        task check_event(mbid_pkg::t_result got);
            mbid_pkg::t_result want;
            results_checked++;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (kind %0d bit %0d)",
                                          got.event_kind, got.bit_index));
                return;
            end
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_mismatch($sformatf("event_kind %0d, expected %0d",
                                          got.event_kind, want.event_kind));
            if (got.bit_index !== want.bit_index)
                report_mismatch($sformatf("bit_index %0d, expected %0d",
                                          got.bit_index, want.bit_index));
            if (got.level !== want.level)
                report_mismatch($sformatf("level %0d, expected %0d (bit %0d)",
                                          got.level, want.level, want.bit_index));
            if (got.stable_word !== want.stable_word)
                report_mismatch($sformatf("stable_word %h, expected %h",
                                          got.stable_word, want.stable_word));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d (bit %0d)",
                                          got.last, want.last, want.bit_index));
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    mbid_pkg::t_item                 i_in_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    mbid_pkg::t_result               o_out_data;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [mbid_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mbid_pkg::DATA_W-1:0]     i_cfg_data;

    debounce_scoreboard    sb;
    bit                    idling_allowed = 1'b1;

    multi_bit_integrating_debouncer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // transaction monitor on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall) sb.check_event(o_out_data);
            if (i_in_valid && !o_in_stall) sb.predict_events(i_in_data);
        end
    end

    // output stall in bursts, with quiet stretches in between
    initial begin : out_stall_gen
        int burst_left;
        int quiet_left;
        burst_left  = 0;
        quiet_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_left > 0) quiet_left--;
            else if (burst_left == 0 && $urandom_range(0, 49) == 0)
                quiet_left = $urandom_range(20, 60);
            if (idling_allowed && quiet_left == 0 && burst_left == 0
                && $urandom_range(0, 3) == 0)
                burst_left = $urandom_range(1, 5);
            if (!idling_allowed) burst_left = 0;
            i_out_stall = (burst_left > 0);
            if (burst_left > 0) burst_left--;
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results still expected",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // drive one pin transaction and hold it until accepted
    task automatic send_pin_item(input logic [mbid_pkg::OPC_W-1:0] opc,
                                 input logic [mbid_pkg::DATA_W-1:0] word);
        i_in_valid            = 1'b1;
        i_in_data.opcode      = opc;
        i_in_data.sample_word = word;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic pause_input(input int cycles);
        i_in_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // wait until every expected result is out, then let a silent scan finish
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [mbid_pkg::CFG_IDX_W-1:0] index,
                                  input logic [mbid_pkg::DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // bouncing pins around a slowly changing level, plus some noise transactions
    task automatic run_bounce_phase(input int count);
        logic [mbid_pkg::DATA_W-1:0] pin_levels;
        int                          sent;
        int                          pick;
        bit                          gaps_on;
        pin_levels = $urandom;
        sent       = 0;
        gaps_on    = 1'b0;
        if ($urandom_range(0, 1) == 0) begin
            send_pin_item(mbid_pkg::OPC_INIT, pin_levels);
            sent++;
        end
        while (sent < count) begin
            if (sent % 16 == 0) gaps_on = idling_allowed && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_pin_item(mbid_pkg::OPC_INIT, pin_levels ^ ($urandom & $urandom & $urandom));
                sent++;
            end else if (pick < 9) begin
                send_pin_item(mbid_pkg::OPC_SNAPSHOT, $urandom);
                sent++;
            end else if (pick < 12) begin
                // ignored by the block, not counted
                send_pin_item(OPC_UNUSED, $urandom);
            end else if (pick < 22) begin
                send_pin_item(mbid_pkg::OPC_SAMPLE, $urandom);
                sent++;
            end else begin
                if ($urandom_range(0, 9) == 0) pin_levels ^= $urandom & $urandom;
                send_pin_item(mbid_pkg::OPC_SAMPLE,
                              pin_levels ^ ($urandom & $urandom & $urandom));
                sent++;
            end
            if (idling_allowed && $urandom_range(0, 99) == 0) drain_results();
            else if (gaps_on && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 5));
        end
    endtask

    // stimulus
    initial begin : stimulus
        logic [mbid_pkg::DATA_W-1:0] mask;
        logic [mbid_pkg::CNT_W-1:0]  thresh;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sb          = new();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // before initialize everything is dropped
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'h1234_5678);
        send_pin_item(mbid_pkg::OPC_SNAPSHOT, 32'h0000_0000);
        send_pin_item(OPC_UNUSED, 32'hFFFF_FFFF);
        // reset mask inverts everything, so stable goes all ones
        send_pin_item(mbid_pkg::OPC_INIT, 32'h0000_0000);
        send_pin_item(mbid_pkg::OPC_SNAPSHOT, 32'hFFFF_FFFF);
        // three disagreeing samples flip all inputs at once
        repeat (3) send_pin_item(mbid_pkg::OPC_SAMPLE, 32'hFFFF_FFFF);
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'hFFFF_FFFF);
        send_pin_item(OPC_UNUSED, 32'h0F0F_0F0F);
        // repeated initialize reloads each time
        send_pin_item(mbid_pkg::OPC_INIT, 32'hA5A5_A5A5);
        send_pin_item(mbid_pkg::OPC_INIT, 32'h5A5A_5A5A);
        send_pin_item(mbid_pkg::OPC_SNAPSHOT, 32'h0000_0000);

        // no inversion, single-sample flips
        drain_results();
        write_register(mbid_pkg::CFG_THRESHOLD, 32'd1);
        write_register(mbid_pkg::CFG_INVERT_MASK, 32'h0000_0000);
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'hFFFF_FFFF);
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'h0000_0000);
        send_pin_item(mbid_pkg::OPC_SNAPSHOT, 32'h0000_0000);

        // threshold lowered below counters already built up
        drain_results();
        write_register(mbid_pkg::CFG_THRESHOLD, 32'd15);
        send_pin_item(mbid_pkg::OPC_INIT, 32'h0000_0000);
        repeat (5) send_pin_item(mbid_pkg::OPC_SAMPLE, 32'h8000_0001);
        drain_results();
        write_register(mbid_pkg::CFG_THRESHOLD, 32'd2);
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'h8000_0001);

        // zero threshold flips on the first disagreement
        drain_results();
        write_register(mbid_pkg::CFG_THRESHOLD, 32'd0);
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'h0000_FFFF);
        send_pin_item(mbid_pkg::OPC_SAMPLE, 32'hFFFF_0000);

        // random phases, one register setting each, last one without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    mask   = mbid_pkg::RESET_INVERT_MASK;
                    thresh = mbid_pkg::RESET_THRESHOLD;
                end
                1:       begin mask = 32'h0000_0000; thresh = 4'd1;  end
                2:       begin mask = $urandom;      thresh = 4'd15; end
                3:       begin mask = $urandom;      thresh = 4'd0;  end
                4: begin
                    mask   = $urandom;
                    thresh = mbid_pkg::CNT_W'($urandom_range(1, 15));
                end
                default: begin mask = 32'h0000_0000; thresh = 4'd2;  end
            endcase
            write_register(mbid_pkg::CFG_INVERT_MASK, mask);
            write_register(mbid_pkg::CFG_THRESHOLD,
                           {{(mbid_pkg::DATA_W-mbid_pkg::CNT_W){1'b0}}, thresh});
            idling_allowed = (p != NUM_PHASES - 1);
            run_bounce_phase(ITEMS_PER_PHASE);
        end

        drain_results();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d input transactions, %0d change events and %0d snapshots predicted",
                 sb.items_seen, sb.changes_predicted, sb.snapshots_predicted);
        $display("checked %0d results across %0d register writes, %0d mismatches",
                 sb.results_checked, sb.settings_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
